// ===== rtl/mbq_pkg.sv =====
// Shared types and constants for the multichannel biquad filter.
// No dependencies; imported by the filter top level.
`default_nettype none

package mbq_pkg;

  localparam int COEF_W    = 32;
  localparam int CH_W      = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int ACTIVE_W  = 4;

  typedef enum logic [2:0] {
    REG_COEF_B0         = 3'd0,
    REG_COEF_B1         = 3'd1,
    REG_COEF_B2         = 3'd2,
    REG_COEF_A1         = 3'd3,
    REG_COEF_A2         = 3'd4,
    REG_FILTER_ENABLE   = 3'd5,
    REG_ACTIVE_CHANNELS = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_biquad_filter_top.sv =====
// Multichannel direct form 1 biquad: stream in/out, APB-style coefficient port.
// Depends on mbq_pkg (register indexes, fixed widths).
`default_nettype none

// Takes one sample per cycle while out_tready does not stall the output and returns one
// result per sample through the input register, then the result register; a new transfer
// can be taken every such cycle, also for the same channel back to back. The cycle path is
// the five parallel 32 x SAMPLE_BITS multiplies feeding one exact sum, rounding
// and saturation. Coefficients are signed Q4.28 and shared by all channels; each
// channel below active_channels keeps its own two-input, two-output history.
// Writing active_channels clears the history of all channels. With filter_enable low,
// or on an inactive channel, the sample passes through and history holds.
module multichannel_biquad_filter_top
  import mbq_pkg::*;
#(
  parameter int MAX_CHANNELS   = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample_in
  input  wire logic [CH_W-1:0]                     in_tuser,   // channel_in
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,  // sample_out
  output logic [CH_W-1:0]                          out_tuser,  // channel_out
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]               cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]               cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                    cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_EXT_W = (CH_IDX_W > CH_W) ? CH_IDX_W : CH_W;
  localparam int PROD_W   = COEF_W + SAMPLE_BITS;
  localparam int ACC_W    = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // configuration
  logic signed [COEF_W-1:0]   coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic                       filter_enable_r;
  logic [ACTIVE_W-1:0]        active_channels_r;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;
  logic                       hist_clear;

  // pipeline
  logic                       s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CH_W-1:0]            s1_ch_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CH_W-1:0]            out_ch_r;
  logic                       advance;
  logic                       in_xfer;

  // history
  logic signed [SAMPLE_BITS-1:0] hist_x1_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hist_x2_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hist_y1_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hist_y2_r [MAX_CHANNELS];

  // datapath
  logic [CH_EXT_W-1:0]        ch_ext;
  logic [CH_IDX_W-1:0]        ch_idx;
  logic                       filt_go;
  logic signed [PROD_W-1:0]   prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_shift;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SAMPLE_BITS-1:0] result;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign hist_clear = cfg_wr && (cfg_idx == REG_ACTIVE_CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r         <= COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
      coef_b1_r         <= '0;
      coef_b2_r         <= '0;
      coef_a1_r         <= '0;
      coef_a2_r         <= '0;
      filter_enable_r   <= 1'b1;
      active_channels_r <= ACTIVE_W'(2);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COEF_B0:         coef_b0_r <= cfg_pwdata;
        REG_COEF_B1:         coef_b1_r <= cfg_pwdata;
        REG_COEF_B2:         coef_b2_r <= cfg_pwdata;
        REG_COEF_A1:         coef_a1_r <= cfg_pwdata;
        REG_COEF_A2:         coef_a2_r <= cfg_pwdata;
        REG_FILTER_ENABLE:   filter_enable_r <= cfg_pwdata[0];
        REG_ACTIVE_CHANNELS: active_channels_r <= cfg_pwdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COEF_B0:         cfg_prdata = coef_b0_r;
      REG_COEF_B1:         cfg_prdata = coef_b1_r;
      REG_COEF_B2:         cfg_prdata = coef_b2_r;
      REG_COEF_A1:         cfg_prdata = coef_a1_r;
      REG_COEF_A2:         cfg_prdata = coef_a2_r;
      REG_FILTER_ENABLE:   cfg_prdata = CFG_DATA_W'(filter_enable_r);
      REG_ACTIVE_CHANNELS: cfg_prdata = CFG_DATA_W'(active_channels_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
      s1_ch_r     <= in_tuser;
    end
  end

  // filter datapath
  assign ch_ext  = CH_EXT_W'(s1_ch_r);
  assign ch_idx  = ch_ext[CH_IDX_W-1:0];
  assign filt_go = filter_enable_r
                && ({1'b0, s1_ch_r} < active_channels_r)
                && (32'(s1_ch_r) < MAX_CHANNELS);

  assign prod_b0 = coef_b0_r * s1_sample_r;
  assign prod_b1 = coef_b1_r * hist_x1_r[ch_idx];
  assign prod_b2 = coef_b2_r * hist_x2_r[ch_idx];
  assign prod_a1 = coef_a1_r * hist_y1_r[ch_idx];
  assign prod_a2 = coef_a2_r * hist_y2_r[ch_idx];

  assign acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
             - ACC_W'(prod_a1) - ACC_W'(prod_a2) + RND;
  assign acc_shift = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_shift > SAT_MAX) begin
      y_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (acc_shift < SAT_MIN) begin
      y_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = acc_shift[SAMPLE_BITS-1:0];
    end
  end

  assign result = filt_go ? y_sat : s1_sample_r;

  // history update
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_x1_r[i] <= '0;
        hist_x2_r[i] <= '0;
        hist_y1_r[i] <= '0;
        hist_y2_r[i] <= '0;
      end
    end else if (s1_valid_r && advance && filt_go) begin
      hist_x2_r[ch_idx] <= hist_x1_r[ch_idx];
      hist_x1_r[ch_idx] <= s1_sample_r;
      hist_y2_r[ch_idx] <= hist_y1_r[ch_idx];
      hist_y1_r[ch_idx] <= y_sat;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_sample_r <= result;
      out_ch_r     <= s1_ch_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($unsigned(out_sample_r));
  assign out_tuser  = out_ch_r;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full");

  a_xfer_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("input transfer lost");

  a_bypass_exact: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance && !filt_go |=> out_sample_r == $past(s1_sample_r))
    else $error("pass-through sample altered");

  a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
    hist_clear |=> hist_x1_r[0] == '0 && hist_y1_r[0] == '0)
    else $error("history not cleared on channel count write");

endmodule

`default_nettype wire
